FILE: rtl/htld_pkg.sv
`default_nettype none

package htld_pkg;

    localparam int MAX_LEAVES_DEF = 256;

    localparam int LEAF_TOTAL_W = 9;
    localparam logic [LEAF_TOTAL_W-1:0] LEAF_TOTAL_RST = 9'd256;

    // request modes
    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_LOAD   = 2'd1;
    localparam logic [1:0] MODE_DECODE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SYM  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [1:0] ST_ERR  = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic       node_is_leaf;
        logic [7:0] leaf_byte;
        logic       code_bit;
    } htld_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] symbol;
    } htld_out_t;

    typedef struct packed {
        logic start;
        logic push;
        logic pop;
    } stack_cmd_t;

    typedef struct packed {
        logic attr_we;
        logic right_we;
        logic rd_en;
    } node_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/htld_slot_stack.sv
`default_nettype none

module htld_slot_stack
    import htld_pkg::*;
#(
    parameter int MAX_LEAVES = MAX_LEAVES_DEF,
    localparam int NW = $clog2(2 * MAX_LEAVES),
    localparam int DW = $clog2(MAX_LEAVES + 1),
    localparam int SW = NW + 1
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire stack_cmd_t      cmd,
    input  wire logic [NW-1:0]   node_idx,
    output logic      [DW-1:0]   depth,
    output logic      [SW-1:0]   top
);

    localparam int SAW = $clog2(MAX_LEAVES);

    // entries below the top live in memory; the top is held in a register
    logic [SW-1:0]  slot_mem [MAX_LEAVES];
    logic [SW-1:0]  rdata_reg;

    logic [SW-1:0]  top_reg;
    logic [SW-1:0]  top_next;
    logic           from_mem_reg;
    logic           from_mem_next;
    logic [DW-1:0]  depth_reg;
    logic [DW-1:0]  depth_next;

    logic           wr_en;
    logic [SAW-1:0] wr_addr;
    logic [SW-1:0]  wr_data;
    logic           rd_en;
    logic [SAW-1:0] rd_addr;

    assign top   = from_mem_reg ? rdata_reg : top_reg;
    assign depth = depth_reg;

    always_comb
    begin
        top_next      = top;
        from_mem_next = 1'b0;
        depth_next    = depth_reg;
        wr_en         = 1'b0;
        wr_addr       = SAW'(depth_reg - DW'(1));
        wr_data       = {node_idx, 1'b1};
        rd_en         = 1'b0;
        rd_addr       = SAW'(depth_reg - DW'(2));
        priority if (cmd.start)
        begin
            // root right slot below, root left slot on top
            wr_en      = 1'b1;
            wr_addr    = '0;
            wr_data    = {NW'(0), 1'b1};
            top_next   = {NW'(0), 1'b0};
            depth_next = DW'(2);
        end
        else if (cmd.push)
        begin
            // popped slot becomes the right slot, left slot goes on top
            wr_en      = 1'b1;
            top_next   = {node_idx, 1'b0};
            depth_next = depth_reg + DW'(1);
        end
        else if (cmd.pop)
        begin
            depth_next = depth_reg - DW'(1);
            if (depth_reg > DW'(1))
            begin
                rd_en         = 1'b1;
                from_mem_next = 1'b1;
            end
        end
        else
        begin
            from_mem_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= slot_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg      <= '0;
            from_mem_reg <= 1'b0;
            depth_reg    <= '0;
        end
        else
        begin
            top_reg      <= top_next;
            from_mem_reg <= from_mem_next;
            depth_reg    <= depth_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/htld_node_store.sv
`default_nettype none

module htld_node_store
    import htld_pkg::*;
#(
    parameter int MAX_LEAVES = MAX_LEAVES_DEF,
    localparam int NW = $clog2(2 * MAX_LEAVES)
)
(
    input  wire logic          clk,
    input  wire node_cmd_t     cmd,
    input  wire logic [NW-1:0] attr_addr,
    input  wire logic          attr_leaf,
    input  wire logic [7:0]    attr_byte,
    input  wire logic [NW-1:0] right_addr,
    input  wire logic [NW-1:0] right_data,
    input  wire logic [NW-1:0] rd_addr,
    output logic               rd_leaf,
    output logic      [7:0]    rd_byte,
    output logic      [NW-1:0] rd_right
);

    localparam int ND = 2 * MAX_LEAVES - 1;

    // leaf flag and byte per node, written when the node is created
    logic [8:0]    attr_mem [ND];
    // right child per internal node; cleared when its left slot fills
    logic [NW-1:0] right_mem [ND];

    logic [8:0]    attr_rdata_reg;
    logic [NW-1:0] right_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.attr_we)
        begin
            attr_mem[attr_addr] <= {attr_leaf, attr_byte};
        end
        if (cmd.rd_en)
        begin
            attr_rdata_reg <= attr_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.right_we)
        begin
            right_mem[right_addr] <= right_data;
        end
        if (cmd.rd_en)
        begin
            right_rdata_reg <= right_mem[rd_addr];
        end
    end

    assign rd_leaf  = attr_rdata_reg[8];
    assign rd_byte  = attr_rdata_reg[7:0];
    assign rd_right = right_rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/huffman_tree_load_and_decode.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall  in_item  (htld_in_t)
// result    out        out_valid/ out_stall out_item (htld_out_t)
// config    in         cfg_wr_en            cfg_wr_data (leaf total)
//
// One request is taken per cycle unless stalled; its result passes the second stage
// and the output register. Decode steps run back to back: the pending node read is
// forwarded into the next step's child select. Load records pop the stack top
// straight from the stack memory read. Reset clears counters and flags only; the
// memories start undefined and are read only where the counters mark them filled.
// A stalled result holds the output register, then the second stage, then in_stall.

module huffman_tree_load_and_decode
    import htld_pkg::*;
#(
    parameter int MAX_LEAVES = MAX_LEAVES_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire htld_in_t                in_item,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output htld_out_t                    out_item,
    input  wire logic                    cfg_wr_en,
    input  wire logic [LEAF_TOTAL_W-1:0] cfg_wr_data
);

    localparam int NW = $clog2(2 * MAX_LEAVES);
    localparam int ND = 2 * MAX_LEAVES - 1;
    localparam int LW = $clog2(MAX_LEAVES + 1);
    localparam int DW = $clog2(MAX_LEAVES + 1);
    localparam logic [LEAF_TOTAL_W-1:0] MAX_CNT = LEAF_TOTAL_W'(MAX_LEAVES);

    // configuration
    logic [LEAF_TOTAL_W-1:0] leaf_total_reg;
    logic [LEAF_TOTAL_W-1:0] eff_count;

    // tree state
    logic [NW-1:0] nodes_used_reg;
    logic [NW-1:0] nodes_used_next;
    logic [LW-1:0] leaves_reg;
    logic [LW-1:0] leaves_next;
    logic          tree_ready_reg;
    logic          tree_ready_next;
    logic [NW-1:0] walk_reg;
    logic [NW-1:0] walk_next;
    logic [NW-1:0] walk_right_reg;
    logic [NW-1:0] walk_right_next;
    logic [NW-1:0] root_right_reg;
    logic [NW-1:0] root_right_next;

    // second stage
    logic          s2_valid_reg;
    logic          s2_step_reg;
    logic [NW-1:0] s2_nxt_reg;
    logic [1:0]    s2_status_reg;
    htld_out_t     s2_result;

    // output register
    logic          out_valid_reg;
    htld_out_t     out_item_reg;

    logic          accept;
    logic          s2_adv;
    logic          s1_step;
    logic [1:0]    s1_status;

    // stack and node store
    stack_cmd_t    stack_cmd;
    logic [DW-1:0] depth;
    logic [NW:0]   top;
    node_cmd_t     node_cmd;
    logic [NW-1:0] right_data;
    logic [NW-1:0] parent;
    logic          side;
    logic          rd_leaf;
    logic [7:0]    rd_byte;
    logic [NW-1:0] rd_right;

    // decode step select
    logic [NW-1:0] walk_eff;
    logic [NW-1:0] walk_right_eff;
    logic [NW:0]   cur_plus1;
    logic          left_ok;
    logic          dec_ok;
    logic [NW-1:0] dec_nxt;

    logic                  load_err;
    logic [LEAF_TOTAL_W:0] leaves_plus1;

    assign s2_adv   = !out_valid_reg || !out_stall;
    assign in_stall = s2_valid_reg && !s2_adv;
    assign accept   = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign parent = top[NW:1];
    assign side   = top[0];

    // clamp the leaf total into the supported range
    always_comb
    begin
        priority if (leaf_total_reg < LEAF_TOTAL_W'(2))
        begin
            eff_count = LEAF_TOTAL_W'(2);
        end
        else if (leaf_total_reg > MAX_CNT)
        begin
            eff_count = MAX_CNT;
        end
        else
        begin
            eff_count = leaf_total_reg;
        end
    end

    assign leaves_plus1 = (LEAF_TOTAL_W+1)'(leaves_reg) + (LEAF_TOTAL_W+1)'(1);

    assign load_err = (nodes_used_reg == '0) || tree_ready_reg || (depth == '0)
                      || (nodes_used_reg >= NW'(ND))
                      || (!in_item.node_is_leaf && (depth == DW'(MAX_LEAVES)));

    // forward the walk position of a step still in the second stage
    always_comb
    begin
        if (s2_valid_reg && s2_step_reg)
        begin
            walk_eff       = rd_leaf ? '0 : s2_nxt_reg;
            walk_right_eff = rd_leaf ? root_right_reg : rd_right;
        end
        else
        begin
            walk_eff       = walk_reg;
            walk_right_eff = walk_right_reg;
        end
    end

    // left child is the next node in preorder, present once a later node exists;
    // the right child counts only once the left slot is filled
    assign cur_plus1 = {1'b0, walk_eff} + (NW+1)'(1);
    assign left_ok   = cur_plus1 < {1'b0, nodes_used_reg};

    always_comb
    begin
        if (in_item.code_bit)
        begin
            dec_ok  = left_ok && (walk_right_eff != '0);
            dec_nxt = walk_right_eff;
        end
        else
        begin
            dec_ok  = left_ok;
            dec_nxt = cur_plus1[NW-1:0];
        end
    end

    // first stage: handle the request against the tree state
    always_comb
    begin
        nodes_used_next = nodes_used_reg;
        leaves_next     = leaves_reg;
        tree_ready_next = tree_ready_reg;
        walk_next       = s2_adv ? walk_eff : walk_reg;
        walk_right_next = s2_adv ? walk_right_eff : walk_right_reg;
        root_right_next = root_right_reg;
        stack_cmd       = '0;
        node_cmd        = '0;
        right_data      = side ? nodes_used_reg : '0;
        s1_step         = 1'b0;
        s1_status       = ST_ERR;
        if (accept)
        begin
            unique case (in_item.mode)
                MODE_START:
                begin
                    stack_cmd.start = 1'b1;
                    nodes_used_next = NW'(1);
                    leaves_next     = '0;
                    tree_ready_next = 1'b0;
                    walk_next       = '0;
                    walk_right_next = '0;
                    root_right_next = '0;
                    s1_status       = ST_OK;
                end
                MODE_LOAD:
                begin
                    if (!load_err)
                    begin
                        // create the node and link it into the popped slot
                        node_cmd.attr_we  = 1'b1;
                        node_cmd.right_we = 1'b1;
                        nodes_used_next   = nodes_used_reg + NW'(1);
                        if (parent == '0)
                        begin
                            root_right_next = right_data;
                        end
                        s1_status = ST_OK;
                        if (in_item.node_is_leaf)
                        begin
                            stack_cmd.pop = 1'b1;
                            leaves_next   = leaves_reg + LW'(1);
                            if (leaves_plus1 >= (LEAF_TOTAL_W+1)'(eff_count))
                            begin
                                tree_ready_next = 1'b1;
                                walk_next       = '0;
                                walk_right_next = root_right_next;
                                s1_status       = ST_DONE;
                            end
                        end
                        else
                        begin
                            stack_cmd.push = 1'b1;
                        end
                    end
                end
                MODE_DECODE:
                begin
                    if (tree_ready_reg)
                    begin
                        if (dec_ok)
                        begin
                            // read the child; the second stage finishes the step
                            node_cmd.rd_en = 1'b1;
                            s1_step        = 1'b1;
                            s1_status      = ST_OK;
                        end
                        else
                        begin
                            // empty child: return to the root
                            walk_next       = '0;
                            walk_right_next = root_right_reg;
                        end
                    end
                end
                default:
                begin
                    s1_status = ST_ERR;
                end
            endcase
        end
    end

    htld_slot_stack #(
        .MAX_LEAVES (MAX_LEAVES)
    ) u_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (stack_cmd),
        .node_idx (nodes_used_reg),
        .depth    (depth),
        .top      (top)
    );

    htld_node_store #(
        .MAX_LEAVES (MAX_LEAVES)
    ) u_nodes (
        .clk        (clk),
        .cmd        (node_cmd),
        .attr_addr  (nodes_used_reg),
        .attr_leaf  (in_item.node_is_leaf),
        .attr_byte  (in_item.leaf_byte),
        .right_addr (parent),
        .right_data (right_data),
        .rd_addr    (dec_nxt),
        .rd_leaf    (rd_leaf),
        .rd_byte    (rd_byte),
        .rd_right   (rd_right)
    );

    // second stage: a decode step resolves leaf or internal from the node read
    always_comb
    begin
        if (s2_step_reg)
        begin
            s2_result.status = rd_leaf ? ST_SYM : ST_OK;
            s2_result.symbol = rd_leaf ? rd_byte : 8'd0;
        end
        else
        begin
            s2_result.status = s2_status_reg;
            s2_result.symbol = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaf_total_reg <= LEAF_TOTAL_RST;
            nodes_used_reg <= '0;
            leaves_reg     <= '0;
            tree_ready_reg <= 1'b0;
            walk_reg       <= '0;
            walk_right_reg <= '0;
            root_right_reg <= '0;
            s2_valid_reg   <= 1'b0;
            s2_step_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                leaf_total_reg <= cfg_wr_data;
            end
            nodes_used_reg <= nodes_used_next;
            leaves_reg     <= leaves_next;
            tree_ready_reg <= tree_ready_next;
            walk_reg       <= walk_next;
            walk_right_reg <= walk_right_next;
            root_right_reg <= root_right_next;
            // advance the second stage, or drop it once it moves on
            if (accept)
            begin
                s2_valid_reg <= 1'b1;
                s2_step_reg  <= s1_step;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
                s2_step_reg  <= 1'b0;
            end
            if (s2_adv)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_nxt_reg    <= dec_nxt;
            s2_status_reg <= s1_status;
        end
        if (s2_adv && s2_valid_reg)
        begin
            out_item_reg <= s2_result;
        end
    end

endmodule

`default_nettype wire
